// ----- src/pthsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pthsc_pkg
// Payload types, register indexes and pipeline depths shared by the
// sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package pthsc_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_pth_in;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic [16:0]        humidity;
        logic               pressure_divisor_zero;
    } t_pth_out;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LO   = 3'd1,
        CFG_PRESS_HI   = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_HUM        = 3'd4
    } t_cfg_idx;

    localparam int unsigned FRONT_STAGES = 10;
    localparam int unsigned DIV_STAGES   = 64;
    localparam int unsigned BACK_STAGES  = 5;
    localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

endpackage

`default_nettype wire

// ----- src/pth_sensor_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// pth_sensor_compensation_unit
// Fixed-point temperature, pressure and humidity compensation, fully
// pipelined with a one-bit-per-stage 64-bit signed divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_data  (t_pth_in)
//  result    out        o_valid / i_stall         o_data  (t_pth_out)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One item enters per cycle while no result is stalled; each result
//  passes 10 front stages, 64 divider stages and 5 back stages.
//  The divider, one quotient bit per stage, sets the latency.
//  A stalled result freezes the whole pipeline; nothing is dropped.
//  Synchronous active-low reset clears valid bits and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module pth_sensor_compensation_unit
    import pthsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_pth_in              i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_pth_out             o_data,
    input  logic                 i_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // ---------------- configuration ----------------
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_nine;
    logic [63:0] r_hum_coeffs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_lo    <= '0;
            r_press_hi    <= '0;
            r_press_nine  <= '0;
            r_hum_coeffs  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP:       r_temp_coeffs <= i_cfg_data[47:0];
                CFG_PRESS_LO:   r_press_lo    <= i_cfg_data;
                CFG_PRESS_HI:   r_press_hi    <= i_cfg_data;
                CFG_PRESS_NINE: r_press_nine  <= i_cfg_data[15:0];
                CFG_HUM:        r_hum_coeffs  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0]        c_t1;
    logic signed [15:0] c_t2, c_t3;
    logic [15:0]        c_p1;
    logic signed [15:0] c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic [7:0]         c_h1, c_h3;
    logic signed [15:0] c_h2;
    logic signed [11:0] c_h4, c_h5;
    logic signed [7:0]  c_h6;

    assign c_t1 = r_temp_coeffs[15:0];
    assign c_t2 = r_temp_coeffs[31:16];
    assign c_t3 = r_temp_coeffs[47:32];
    assign c_p1 = r_press_lo[15:0];
    assign c_p2 = r_press_lo[31:16];
    assign c_p3 = r_press_lo[47:32];
    assign c_p4 = r_press_lo[63:48];
    assign c_p5 = r_press_hi[15:0];
    assign c_p6 = r_press_hi[31:16];
    assign c_p7 = r_press_hi[47:32];
    assign c_p8 = r_press_hi[63:48];
    assign c_p9 = r_press_nine;
    assign c_h1 = r_hum_coeffs[7:0];
    assign c_h2 = r_hum_coeffs[23:8];
    assign c_h3 = r_hum_coeffs[31:24];
    assign c_h4 = r_hum_coeffs[43:32];
    assign c_h5 = r_hum_coeffs[55:44];
    assign c_h6 = r_hum_coeffs[63:56];

    // ---------------- pipeline control ----------------
    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // ---------------- front stages: next values ----------------
    logic signed [17:0] n1_ta;
    logic signed [16:0] n1_td;
    logic signed [33:0] n1_m1, n1_dd;

    logic signed [31:0] n2_dds, n2_v1, n2_v2;
    logic signed [47:0] n2_m3;

    logic [31:0]        n3_fine;

    logic [31:0]        n4_f5, n4_hv;
    logic signed [31:0] n4_temp;
    logic signed [32:0] n4_pv1;

    logic signed [65:0] n5_psq;
    logic signed [48:0] n5_pm5, n5_pm2;
    logic signed [43:0] n5_h5v;
    logic [31:0]        n5_hsum;
    logic signed [31:0] n5_ha;
    logic signed [39:0] n5_hbm;
    logic signed [40:0] n5_hcm;

    logic signed [79:0] n6_pa, n6_pb;
    logic signed [31:0] n6_hb, n6_hcs;
    logic [31:0]        n6_hc;
    logic signed [63:0] n6_bc;

    logic [63:0]        n7_v2, n7_v1;
    logic signed [63:0] n7_pbs;
    logic signed [31:0] n7_bcs;
    logic [31:0]        n7_e, n7_e2;
    logic signed [47:0] n7_em;

    logic [20:0]        n8_pp;
    logic [63:0]        n8_n0, n8_wsum;
    logic [79:0]        n8_w;
    logic signed [31:0] n8_e3;
    logic signed [63:0] n8_hv;

    logic signed [63:0] n9_d;
    logic [75:0]        n9_n;
    logic signed [31:0] n9_s;
    logic signed [63:0] n9_g;

    logic               n10_neg, n10_zero;
    logic [63:0]        n10_mn, n10_md;
    logic signed [31:0] n10_g7, n10_ghs;
    logic signed [40:0] n10_gh;
    logic [31:0]        n10_hv, n10_hcl;

    // ---------------- front stages: registers ----------------
    logic [31:0]        r1_m1, r1_dd;
    logic [19:0]        r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp;
    logic [15:0]        r1_rh, r2_rh, r3_rh, r4_rh;
    logic signed [31:0] r2_v1, r2_v2;
    logic [31:0]        r3_fine;
    logic [31:0]        r4_temp, r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp;
    logic signed [32:0] r4_pv1;
    logic [31:0]        r4_hv;
    logic [63:0]        r5_psq;
    logic signed [48:0] r5_pm5, r5_pm2, r6_pm5, r6_pm2;
    logic [31:0]        r5_ha, r5_hbm, r5_hcm, r6_ha, r6_bc, r7_ha, r7_e2;
    logic [63:0]        r6_pa, r6_pb, r7_v1, r7_v2;
    logic [63:0]        r8_w, r8_n0;
    logic [31:0]        r8_hv, r9_hv, r9_g;
    logic [63:0]        r9_d, r9_n;
    logic [63:0]        r10_mn, r10_md;
    logic               r10_neg, r10_zero;
    logic [16:0]        r10_hum;

    always_comb begin
        // S1: temperature differences and first products
        n1_ta = $signed({1'b0, i_data.raw_temperature[19:3]}) - $signed({1'b0, c_t1, 1'b0});
        n1_td = $signed({1'b0, i_data.raw_temperature[19:4]}) - $signed({1'b0, c_t1});
        n1_m1 = n1_ta * c_t2;
        n1_dd = n1_td * n1_td;

        // S2
        n2_dds = $signed(r1_dd) >>> 12;
        n2_m3  = n2_dds * c_t3;
        n2_v1  = $signed(r1_m1) >>> 11;
        n2_v2  = $signed(n2_m3[31:0]) >>> 14;

        // S3: fine temperature
        n3_fine = r2_v1 + r2_v2;

        // S4
        n4_f5   = r3_fine * 32'd5 + 32'd128;
        n4_temp = $signed(n4_f5) >>> 8;
        n4_pv1  = $signed({r3_fine[31], r3_fine}) - 33'sd128000;
        n4_hv   = r3_fine - 32'd76800;

        // S5
        n5_psq  = r4_pv1 * r4_pv1;
        n5_pm5  = r4_pv1 * c_p5;
        n5_pm2  = r4_pv1 * c_p2;
        n5_h5v  = c_h5 * $signed(r4_hv);
        n5_hsum = {2'b00, r4_rh, 14'b0} - {c_h4, 20'b0} - n5_h5v[31:0] + 32'd16384;
        n5_ha   = $signed(n5_hsum) >>> 15;
        n5_hbm  = $signed(r4_hv) * c_h6;
        n5_hcm  = $signed(r4_hv) * $signed({1'b0, c_h3});

        // S6
        n6_pa  = $signed(r5_psq) * c_p6;
        n6_pb  = $signed(r5_psq) * c_p3;
        n6_hb  = $signed(r5_hbm) >>> 10;
        n6_hcs = $signed(r5_hcm) >>> 11;
        n6_hc  = n6_hcs + 32'd32768;
        n6_bc  = n6_hb * $signed(n6_hc);

        // S7
        n7_v2  = r6_pa + ({{15{r6_pm5[48]}}, r6_pm5} << 17)
                       + ({{48{c_p4[15]}}, c_p4} << 35);
        n7_pbs = $signed(r6_pb) >>> 8;
        n7_v1  = n7_pbs + ({{15{r6_pm2[48]}}, r6_pm2} << 12);
        n7_bcs = $signed(r6_bc) >>> 10;
        n7_e   = n7_bcs + 32'd2097152;
        n7_em  = $signed(n7_e) * c_h2;
        n7_e2  = n7_em[31:0] + 32'd8192;

        // S8
        n8_pp   = 21'h100000 - {1'b0, r7_rp};
        n8_n0   = ({43'b0, n8_pp} << 31) - r7_v2;
        n8_wsum = 64'h0000_8000_0000_0000 + r7_v1;
        n8_w    = n8_wsum * c_p1;
        n8_e3   = $signed(r7_e2) >>> 14;
        n8_hv   = $signed(r7_ha) * n8_e3;

        // S9: divisor and dividend
        n9_d = $signed(r8_w) >>> 33;
        n9_n = r8_n0 * 12'd3125;
        n9_s = $signed(r8_hv) >>> 15;
        n9_g = n9_s * n9_s;

        // S10: magnitudes for the divider, humidity clamp
        n10_neg  = r9_n[63] ^ r9_d[63];
        n10_mn   = r9_n[63] ? 64'd0 - r9_n : r9_n;
        n10_md   = r9_d[63] ? 64'd0 - r9_d : r9_d;
        n10_zero = (r9_d == 64'd0);
        n10_g7   = $signed(r9_g) >>> 7;
        n10_gh   = n10_g7 * $signed({1'b0, c_h1});
        n10_ghs  = $signed(n10_gh[31:0]) >>> 4;
        n10_hv   = r9_hv - n10_ghs;
        if (n10_hv[31]) begin
            n10_hcl = 32'd0;
        end else if (n10_hv > 32'd419430400) begin
            n10_hcl = 32'd419430400;
        end else begin
            n10_hcl = n10_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m1    <= n1_m1[31:0];
            r1_dd    <= n1_dd[31:0];
            r1_rp    <= i_data.raw_pressure;
            r1_rh    <= i_data.raw_humidity;

            r2_v1    <= n2_v1;
            r2_v2    <= n2_v2;
            r2_rp    <= r1_rp;
            r2_rh    <= r1_rh;

            r3_fine  <= n3_fine;
            r3_rp    <= r2_rp;
            r3_rh    <= r2_rh;

            r4_temp  <= n4_temp;
            r4_pv1   <= n4_pv1;
            r4_hv    <= n4_hv;
            r4_rp    <= r3_rp;
            r4_rh    <= r3_rh;

            r5_psq   <= n5_psq[63:0];
            r5_pm5   <= n5_pm5;
            r5_pm2   <= n5_pm2;
            r5_temp  <= r4_temp;
            r5_rp    <= r4_rp;
            r5_ha    <= n5_ha;
            r5_hbm   <= n5_hbm[31:0];
            r5_hcm   <= n5_hcm[31:0];

            r6_pa    <= n6_pa[63:0];
            r6_pb    <= n6_pb[63:0];
            r6_pm5   <= r5_pm5;
            r6_pm2   <= r5_pm2;
            r6_temp  <= r5_temp;
            r6_rp    <= r5_rp;
            r6_ha    <= r5_ha;
            r6_bc    <= n6_bc[31:0];

            r7_v1    <= n7_v1;
            r7_v2    <= n7_v2;
            r7_temp  <= r6_temp;
            r7_rp    <= r6_rp;
            r7_ha    <= r6_ha;
            r7_e2    <= n7_e2;

            r8_w     <= n8_w[63:0];
            r8_n0    <= n8_n0;
            r8_temp  <= r7_temp;
            r8_hv    <= n8_hv[31:0];

            r9_d     <= n9_d;
            r9_n     <= n9_n[63:0];
            r9_temp  <= r8_temp;
            r9_hv    <= r8_hv;
            r9_g     <= n9_g[31:0];

            r10_mn   <= n10_mn;
            r10_md   <= n10_md;
            r10_neg  <= n10_neg;
            r10_zero <= n10_zero;
            r10_temp <= r9_temp;
            r10_hum  <= n10_hcl[28:12];
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic [63:0]           r_drem [DIV_STAGES];
    logic [63:0]           r_dquo [DIV_STAGES];
    logic [63:0]           r_dmd  [DIV_STAGES];
    logic [31:0]           r_dtemp[DIV_STAGES];
    logic [16:0]           r_dhum [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_dneg, r_dzero;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [63:0] w_rem, w_quo, w_md;
        logic [31:0] w_temp;
        logic [16:0] w_hum;
        logic        w_neg, w_zero, w_ge;
        logic [64:0] w_t, w_diff;

        if (k == 0) begin : g_src
            assign w_rem  = 64'd0;
            assign w_quo  = r10_mn;
            assign w_md   = r10_md;
            assign w_temp = r10_temp;
            assign w_hum  = r10_hum;
            assign w_neg  = r10_neg;
            assign w_zero = r10_zero;
        end else begin : g_src
            assign w_rem  = r_drem[k-1];
            assign w_quo  = r_dquo[k-1];
            assign w_md   = r_dmd[k-1];
            assign w_temp = r_dtemp[k-1];
            assign w_hum  = r_dhum[k-1];
            assign w_neg  = r_dneg[k-1];
            assign w_zero = r_dzero[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign w_t    = {w_rem, w_quo[63]};
        assign w_ge   = (w_t >= {1'b0, w_md});
        assign w_diff = w_t - {1'b0, w_md};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k]  <= w_ge ? w_diff[63:0] : w_t[63:0];
                r_dquo[k]  <= {w_quo[62:0], w_ge};
                r_dmd[k]   <= w_md;
                r_dtemp[k] <= w_temp;
                r_dhum[k]  <= w_hum;
                r_dneg[k]  <= w_neg;
                r_dzero[k] <= w_zero;
            end
        end
    end

    // ---------------- back stages ----------------
    logic [63:0]        n11_q;
    logic signed [63:0] n12_x;
    logic [63:0]        n12_p0;
    logic [31:0]        n12_cr;
    logic signed [79:0] n12_m8;
    logic [63:0]        n13_sq;
    logic signed [63:0] n13_v2;
    logic signed [79:0] n14_m9;
    logic signed [63:0] n15_v1, n15_ss;
    logic [63:0]        n15_sum, n15_p;

    logic [63:0]        r11_q, r12_q, r13_q, r14_q;
    logic [63:0]        r12_p0, r12_m8, r13_sq, r13_v2, r14_m9, r14_v2;
    logic [31:0]        r12_cr;
    logic               r11_zero, r12_zero, r13_zero, r14_zero;
    logic [31:0]        r11_temp, r12_temp, r13_temp, r14_temp;
    logic [16:0]        r11_hum, r12_hum, r13_hum, r14_hum;
    t_pth_out           r_out;

    always_comb begin
        n11_q   = r_dneg[DIV_STAGES-1] ? 64'd0 - r_dquo[DIV_STAGES-1] : r_dquo[DIV_STAGES-1];

        // low 64 bits of x*x from 32-bit halves
        n12_x   = $signed(r11_q) >>> 13;
        n12_p0  = n12_x[31:0] * n12_x[31:0];
        n12_cr  = n12_x[63:32] * n12_x[31:0];
        n12_m8  = $signed(r11_q) * c_p8;

        n13_sq  = r12_p0 + {r12_cr[30:0], 33'b0};
        n13_v2  = $signed(r12_m8) >>> 19;

        n14_m9  = $signed(r13_sq) * c_p9;

        n15_v1  = $signed(r14_m9) >>> 25;
        n15_sum = r14_q + n15_v1 + r14_v2;
        n15_ss  = $signed(n15_sum) >>> 8;
        n15_p   = n15_ss + ({{48{c_p7[15]}}, c_p7} << 4);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_q    <= n11_q;
            r11_zero <= r_dzero[DIV_STAGES-1];
            r11_temp <= r_dtemp[DIV_STAGES-1];
            r11_hum  <= r_dhum[DIV_STAGES-1];

            r12_p0   <= n12_p0;
            r12_cr   <= n12_cr;
            r12_m8   <= n12_m8[63:0];
            r12_q    <= r11_q;
            r12_zero <= r11_zero;
            r12_temp <= r11_temp;
            r12_hum  <= r11_hum;

            r13_sq   <= n13_sq;
            r13_v2   <= n13_v2;
            r13_q    <= r12_q;
            r13_zero <= r12_zero;
            r13_temp <= r12_temp;
            r13_hum  <= r12_hum;

            r14_m9   <= n14_m9[63:0];
            r14_v2   <= r13_v2;
            r14_q    <= r13_q;
            r14_zero <= r13_zero;
            r14_temp <= r13_temp;
            r14_hum  <= r13_hum;

            r_out.temperature           <= r14_temp;
            r_out.pressure              <= r14_zero ? 32'd0 : n15_p[31:0];
            r_out.humidity              <= r14_hum;
            r_out.pressure_divisor_zero <= r14_zero;
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives raw sensor readings through the compensation pipeline under reset, fixed
// and random coefficient sets, predicts each compensated result and compares by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import pthsc_pkg::*;

    // Coefficient registers of the predictor
    logic [47:0] cf_temp;
    logic [63:0] cf_plo, cf_phi, cf_hum;
    logic [15:0] cf_p9;

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] quot64(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic t_pth_out compensate(t_pth_in x);
        t_pth_out r;
        logic [31:0] t1, t2, t3, a, d, fine, v, b, c, e, s, g;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [63:0] w1, w2, p;
        t1 = {16'd0, cf_temp[15:0]};
        t2 = {{16{cf_temp[31]}}, cf_temp[31:16]};
        t3 = {{16{cf_temp[47]}}, cf_temp[47:32]};
        a = {15'd0, x.raw_temperature[19:3]} - (t1 << 1);
        d = {16'd0, x.raw_temperature[19:4]} - t1;
        fine = asr32(a * t2, 11) + asr32(asr32(d * d, 12) * t3, 14);
        r.temperature = asr32(fine * 32'd5 + 32'd128, 8);
        // pressure, 64-bit
        w1 = {{32{fine[31]}}, fine} - 64'd128000;
        w2 = w1 * w1 * sx16(cf_phi[31:16]);
        w2 = w2 + ((w1 * sx16(cf_phi[15:0])) << 17);
        w2 = w2 + (sx16(cf_plo[63:48]) << 35);
        w1 = asr64(w1 * w1 * sx16(cf_plo[47:32]), 8) + ((w1 * sx16(cf_plo[31:16])) << 12);
        w1 = asr64(((64'd1 << 47) + w1) * {48'd0, cf_plo[15:0]}, 33);
        if (w1 == 0) begin
            r.pressure = 0;
            r.pressure_divisor_zero = 1'b1;
        end else begin
            r.pressure_divisor_zero = 1'b0;
            p = 64'd1048576 - {44'd0, x.raw_pressure};
            p = quot64(((p << 31) - w2) * 64'd3125, w1);
            w1 = asr64(sx16(cf_p9) * asr64(p, 13) * asr64(p, 13), 25);
            w2 = asr64(sx16(cf_phi[63:48]) * p, 19);
            p = asr64(p + w1 + w2, 8) + (sx16(cf_phi[47:32]) << 4);
            r.pressure = p[31:0];
        end
        // humidity, 32-bit
        h1 = {24'd0, cf_hum[7:0]};
        h2 = {{16{cf_hum[23]}}, cf_hum[23:8]};
        h3 = {24'd0, cf_hum[31:24]};
        h4 = {{20{cf_hum[43]}}, cf_hum[43:32]};
        h5 = {{20{cf_hum[55]}}, cf_hum[55:44]};
        h6 = {{24{cf_hum[63]}}, cf_hum[63:56]};
        v = fine - 32'd76800;
        a = asr32(({16'd0, x.raw_humidity} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b = asr32(v * h6, 10);
        c = asr32(v * h3, 11) + 32'd32768;
        e = asr32(b * c, 10) + 32'd2097152;
        e = asr32(e * h2 + 32'd8192, 14);
        v = a * e;
        s = asr32(v, 15);
        g = asr32(s * s, 7);
        v = v - asr32(g * h1, 4);
        if (v[31]) v = 0;
        else if (v > 32'd419430400) v = 32'd419430400;
        r.humidity = v[28:12];
        return r;
    endfunction

    class result_board;
        t_pth_out pending[$];
        int errors;
        function void note_input(t_pth_in x);
            pending.push_back(compensate(x));
        endfunction
        function void check_result(t_pth_out got);
            t_pth_out ex;
            if (pending.size() == 0) begin
                $error("result with no item waiting");
                errors++;
                return;
            end
            ex = pending.pop_front();
            if (got.temperature !== ex.temperature) begin
                $error("temperature exp %0d got %0d", ex.temperature, got.temperature);
                errors++;
            end
            if (got.pressure !== ex.pressure) begin
                $error("pressure exp %0h got %0h", ex.pressure, got.pressure);
                errors++;
            end
            if (got.humidity !== ex.humidity) begin
                $error("humidity exp %0d got %0d", ex.humidity, got.humidity);
                errors++;
            end
            if (got.pressure_divisor_zero !== ex.pressure_divisor_zero) begin
                $error("pressure_divisor_zero exp %0b got %0b",
                       ex.pressure_divisor_zero, got.pressure_divisor_zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0, i_cfg_valid = 0;
    t_pth_in i_data = '0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_cfg_ready;
    t_pth_out o_data;

    result_board board = new();
    bit calm = 0;
    int zero_divs = 0;
    longint cycles = 0;

    pth_sensor_compensation_unit dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Check each result that the receiver accepts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_data.pressure_divisor_zero) zero_divs++;
            board.check_result(o_data);
        end
    end

    initial begin : sink_stall
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
                i_stall <= 0;
            end
            @(posedge i_clk);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_TEMP:       cf_temp = val[47:0];
            CFG_PRESS_LO:   cf_plo = val;
            CFG_PRESS_HI:   cf_phi = val;
            CFG_PRESS_NINE: cf_p9 = val[15:0];
            CFG_HUM:        cf_hum = val;
            default: ;
        endcase
    endtask

    // Typical factory coefficients plus random jitter, all-ones or corner words, or fully random words
    task automatic load_coeffs(int mode);
        logic [63:0] r [5];
        if (mode == 0) begin
            r[0] = {16'd0, 16'd50, 16'd26435, 16'd27504};
            r[1] = {16'd2855, 16'h0BD0, 16'hD4BC, 16'd36477};
            r[2] = {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140};
            r[3] = 64'd6000;
            r[4] = {8'd30, 12'd50, 12'd312, 8'd0, 16'd362, 8'd75};
            foreach (r[k]) r[k] = r[k] ^ 64'($urandom_range(0, 15) << 1);
        end else if (mode == 1) begin
            foreach (r[k]) r[k] = '1;
        end else if (mode == 2) begin
            r[0] = {16'd0, 16'h8000, 16'h8000, 16'hFFFF};
            r[1] = {16'h8000, 16'h7FFF, 16'h8000, 16'h0000};
            r[2] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
            r[3] = 64'h8000;
            r[4] = 64'h7F7FF800FF7FFF00;
        end else begin
            foreach (r[k]) r[k] = {$urandom, $urandom};
        end
        write_reg(CFG_TEMP, r[0]);
        write_reg(CFG_PRESS_LO, r[1]);
        write_reg(CFG_PRESS_HI, r[2]);
        write_reg(CFG_PRESS_NINE, r[3]);
        write_reg(CFG_HUM, r[4]);
    endtask

    task automatic send_item(t_pth_in x);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(x);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    function automatic t_pth_in random_item();
        t_pth_in x;
        x.raw_temperature = 20'($urandom_range(0, 3) == 0 ? $urandom
                                                           : $urandom_range(400000, 600000));
        x.raw_pressure = 20'($urandom_range(0, 3) == 0 ? $urandom
                                                        : $urandom_range(250000, 450000));
        x.raw_humidity = 16'($urandom);
        return x;
    endfunction

    initial begin : stimulus
        t_pth_in x;
        cf_temp = 0; cf_plo = 0; cf_phi = 0; cf_p9 = 0; cf_hum = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Reset coefficients: divisor is zero for every item
        send_item('0);
        send_item('1);
        drain();
        load_coeffs(0);
        send_item('0);
        send_item('1);
        send_item({20'h80000, 20'h80000, 16'h8000});
        send_item({20'd519888, 20'd415148, 16'd27000});
        send_item({20'hFFFFF, 20'd0, 16'd0});
        send_item({20'd0, 20'hFFFFF, 16'hFFFF});
        drain();
        for (int ph = 1; ph < 8; ph++) begin
            load_coeffs(ph < 3 ? ph : (ph % 2 == 0 ? 0 : 3));
            send_item('0);
            send_item('1);
            for (int k = 0; k < 218; k++) begin
                x = random_item();
                if (ph == 7 && k >= 100) calm = 1;
                send_item(x);
            end
            drain();
        end
        $display("covered %0d coefficient sets with stalls on both sides, %0d divide-by-zero results",
                 9, zero_divs);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
src/pthsc_pkg.sv
src/pth_sensor_compensation_unit.sv
test/tb_top.sv
